[rtl/core/rcd_pkg.sv]
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants of the serial channel deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcd_pkg;

	localparam int MAX_AXES          = 8;
	localparam int SYNC_HITS_NEEDED  = 5;
	localparam int AXIS_LIMIT        = (MAX_AXES > 15) ? 15 : MAX_AXES;

	localparam int BYTE_W   = 8;
	localparam int BTN_W    = 4;
	localparam int HITS_W   = 3;
	localparam int AXIS_W   = 3;
	localparam int POS_W    = 16;
	localparam int COUNT_W  = 5;
	localparam int CFG_IDX_W = 2;
	localparam int DIFF_W   = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_SLOTS   = 2'd1;

	localparam logic [BYTE_W-1:0] SYNC_THRESHOLD_RST = 8'd255;
	localparam logic [BTN_W-1:0]  BUTTON_SLOTS_RST   = 4'd0;

	localparam logic KIND_AXIS  = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	localparam logic [HITS_W-1:0] HITS_MAX  = 3'd7;
	localparam logic [BYTE_W-1:0] COUNT_MAX = 8'd255;

	// byte*65536+175 over 350 equals (byte*32768+87) over 175,
	// done as a multiply by ceil(2^32/175) and a 32 bit shift
	localparam int                POS_NUM_W   = 24;
	localparam int                POS_RECIP_W = 25;
	localparam int                POS_SHIFT   = 32;
	localparam logic [14:0]       POS_HALF    = 15'd87;
	localparam logic [POS_RECIP_W-1:0] POS_RECIP = 25'd24542671;
	localparam logic [16:0]       POS_OFFSET  = 17'd16384;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_COUNT = 2'd1,
		PH_SYNC  = 2'd2
	} phase_t;

	typedef struct packed {
		logic                      valid;
		logic                      kind;
		logic [AXIS_W-1:0]         axis;
		logic signed [COUNT_W-1:0] count;
	} ctrl_res_t;

endpackage

`default_nettype wire

[rtl/core/rcd_scale.sv]
// ----------------------------------------------------------------------------
// rcd_scale
// Maps a data byte to its signed Q1.15 stick position, byte/175 - 0.5.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_scale
	import rcd_pkg::*;
(
	input  wire logic [BYTE_W-1:0]       rx_byte,
	output logic signed [POS_W-1:0]      position
);

	logic [POS_NUM_W-1:0]                 num;
	logic [POS_NUM_W+POS_RECIP_W-1:0]     prod;
	logic [16:0]                          quot;
	logic [16:0]                          diff;

	always_comb begin
		num      = {1'b0, rx_byte, POS_HALF};
		prod     = num * POS_RECIP;
		quot     = prod[POS_SHIFT +: 17];
		diff     = quot - POS_OFFSET;
		position = signed'(diff[POS_W-1:0]);
	end

endmodule

`default_nettype wire

[rtl/core/rcd_ctrl.sv]
// ----------------------------------------------------------------------------
// rcd_ctrl
// Sync hunt, slot counting and slot tracking for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_ctrl
	import rcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic [BYTE_W-1:0] sync_threshold,
	input  wire logic [BTN_W-1:0]  button_slots,
	output ctrl_res_t              res
);

	phase_t              phase_q, phase_d;
	logic [HITS_W-1:0]   hits_q, hits_d;
	logic [BYTE_W-1:0]   slots_q, slots_d;
	logic [BYTE_W-1:0]   slot_pos_q, slot_pos_d;

	logic                       is_sync;
	logic signed [DIFF_W-1:0]   diff_cnt;
	logic signed [DIFF_W-1:0]   diff_ch;
	logic [HITS_W-1:0]          hits_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			hits_q     <= '0;
			slots_q    <= '0;
			slot_pos_q <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			hits_q     <= hits_d;
			slots_q    <= slots_d;
			slot_pos_q <= slot_pos_d;
		end
	end

	always_comb begin
		is_sync  = rx_byte >= sync_threshold;
		diff_cnt = signed'({2'b00, slots_q}) - signed'({6'd0, button_slots});
		diff_ch  = signed'({2'b00, slot_pos_q}) - signed'({6'd0, button_slots});
		hits_inc = hits_q + ((is_sync && hits_q < HITS_MAX) ? 3'd1 : 3'd0);

		phase_d    = phase_q;
		hits_d     = hits_q;
		slots_d    = slots_q;
		slot_pos_d = slot_pos_q;
		res        = '0;

		case (phase_q)
			PH_COUNT: begin
				hits_d = '0;
				if (!is_sync) begin
					if (slots_q < COUNT_MAX)
						slots_d = slots_q + 8'd1;
				end else begin
					phase_d   = PH_SYNC;
					res.valid = 1'b1;
					res.kind  = KIND_COUNT;
					if (diff_cnt > DIFF_W'(AXIS_LIMIT))
						res.count = COUNT_W'(AXIS_LIMIT);
					else
						res.count = diff_cnt[COUNT_W-1:0];
				end
			end
			PH_SYNC: begin
				if (is_sync) begin
					slot_pos_d = '0;
				end else begin
					if (diff_ch >= 0 && diff_ch < DIFF_W'(MAX_AXES)) begin
						res.valid = 1'b1;
						res.kind  = KIND_AXIS;
						res.axis  = diff_ch[AXIS_W-1:0];
					end
					if (slot_pos_q < COUNT_MAX)
						slot_pos_d = slot_pos_q + 8'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				hits_d  = hits_inc;
				if (hits_inc >= HITS_W'(SYNC_HITS_NEEDED)) begin
					phase_d = PH_COUNT;
					slots_d = '0;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/rc_serial_channel_deframer_unit.sv]
// data path: a byte is taken into the input register; once the output is free,
//   any result beat it yields is registered into the output register
// throughput: one byte per cycle when the output is free, set by the single pass
//   from the input register through the scaler multiplier into the output register
// reset: arst_n clears phase, counters and valid flags; registers reload
//   sync_threshold 255 and button_slots 0
// ----------------------------------------------------------------------------
// rc_serial_channel_deframer_unit
// Deframes radio-control serial bytes into axis positions and channel count.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_serial_channel_deframer_unit
	import rcd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // rx_byte
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata,   // axis_index, position, channel_count
	output logic                      m_tuser    // result_kind
);

	logic [BYTE_W-1:0]          sync_threshold_q;
	logic [BTN_W-1:0]           button_slots_q;

	logic                       valid_s1;
	logic [BYTE_W-1:0]          byte_s1;

	logic                       valid_s2;
	logic                       kind_s2;
	logic [AXIS_W-1:0]          axis_s2;
	logic signed [POS_W-1:0]    pos_s2;
	logic signed [COUNT_W-1:0]  count_s2;

	logic                       out_free;
	logic                       adv;
	ctrl_res_t                  res;
	logic signed [POS_W-1:0]    position;

	assign out_free = !valid_s2 || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_threshold_q <= SYNC_THRESHOLD_RST;
			button_slots_q   <= BUTTON_SLOTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_THRESHOLD: sync_threshold_q <= cfg_wdata;
				REG_BUTTON_SLOTS:   button_slots_q   <= cfg_wdata[BTN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	rcd_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv),
		.rx_byte        (byte_s1),
		.sync_threshold (sync_threshold_q),
		.button_slots   (button_slots_q),
		.res            (res)
	);

	rcd_scale u_scale (
		.rx_byte  (byte_s1),
		.position (position)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			kind_s2  <= res.kind;
			axis_s2  <= res.axis;
			pos_s2   <= (res.kind == KIND_AXIS) ? position : '0;
			count_s2 <= res.count;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {count_s2, pos_s2, axis_s2};

endmodule

`default_nettype wire

[rtl/core/rcd_checker.sv]
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_checker
	import rcd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser
);

	// stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("stalled output beat changed");

	// axis beats carry no count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_AXIS |-> m_tdata[23:19] == 5'd0)
	else $error("axis beat with nonzero count");

	// count beats carry no axis or position
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_COUNT |-> m_tdata[18:0] == 19'd0)
	else $error("count beat with axis or position");

	// positions stay within byte/175 - 0.5
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_AXIS |->
			signed'(m_tdata[18:3]) >= -16'sd16384 && signed'(m_tdata[18:3]) <= 16'sd31364)
	else $error("position out of range");

endmodule

bind rc_serial_channel_deframer_unit rcd_checker u_rcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
